[sv/mpml_pkg.sv]
// Shared types and constants for the four-motor power limiter.
`timescale 1ns / 1ps
`default_nettype none

package mpml_pkg;

   localparam int FRAC = 16;
   localparam int MOTORS = 4;
   localparam int SQRT_STEPS = 45;
   localparam int DIV_STEPS = 16;
   localparam int LATENCY = 12 + SQRT_STEPS + 1 + DIV_STEPS + 2;

   localparam logic [2:0] REG_COPPER = 3'd0;
   localparam logic [2:0] REG_FRICTION = 3'd1;
   localparam logic [2:0] REG_STATIC = 3'd2;
   localparam logic [2:0] REG_BASE = 3'd3;
   localparam logic [2:0] REG_RESERVE = 3'd4;
   localparam logic [2:0] REG_GAIN = 3'd5;
   localparam logic [2:0] REG_CLAMP = 3'd6;
   localparam logic [2:0] REG_TORQUE = 3'd7;

   localparam logic [1:0] MODE_ONE = 2'd0;
   localparam logic [1:0] MODE_ZERO = 2'd1;
   localparam logic [1:0] MODE_SOLVE = 2'd2;

   localparam logic [16:0] SCALE_ONE = 17'h10000;

   typedef struct packed {
      logic [MOTORS-1:0][16:0] cmag;
      logic [MOTORS-1:0] neg;
      logic [54:0] power;
      logic [1:0] mode;
   } side_type;

   typedef struct packed {
      side_type side;
      logic [43:0] b;
      logic [26:0] cc;
      logic [89:0] rad;
      logic [47:0] rem;
      logic [44:0] root;
   } sq_type;

   typedef struct packed {
      side_type side;
      logic [45:0] den;
      logic [46:0] rem;
      logic [15:0] quo;
   } div_type;

endpackage

`default_nettype wire

[sv/motor_power_model_limiter_unit.sv]
// Top level of the four-motor power limiter: budget, power model, root and scale pipeline.
//
//   channel   ports                               transfer
//   request   start, busy, req_command_*, ...     start high while busy low
//   response  rsp_valid, rsp_scaled_*, ...        rsp_valid high for one cycle
//   config    csr_we, csr_index, csr_data         csr_we high
//
// A new request can be taken every cycle. The pipeline depth is set chiefly by the 45
// one-bit square root stages and the 16 one-bit divide stages. Synchronous reset clears
// the stage valid bits and the configuration registers but loads the base register
// with 3276800; busy is high only during reset. The receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module motor_power_model_limiter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_command_a,
   input  wire logic signed [15:0] req_command_b,
   input  wire logic signed [15:0] req_command_c,
   input  wire logic signed [15:0] req_command_d,
   input  wire logic signed [26:0] req_speed_a,
   input  wire logic signed [26:0] req_speed_b,
   input  wire logic signed [26:0] req_speed_c,
   input  wire logic signed [26:0] req_speed_d,
   input  wire logic [24:0]        req_buffer_energy,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_scaled_a,
   output logic signed [15:0]      rsp_scaled_b,
   output logic signed [15:0]      rsp_scaled_c,
   output logic signed [15:0]      rsp_scaled_d,
   output logic [16:0]             rsp_scale_factor,
   output logic [31:0]             rsp_predicted_power,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   localparam int M = mpml_pkg::MOTORS;
   localparam int F = mpml_pkg::FRAC;
   localparam int NS = mpml_pkg::SQRT_STEPS;
   localparam int ND = mpml_pkg::DIV_STEPS;

   // Configuration registers.
   logic [20:0] k1_ff, k2_ff;
   logic [22:0] alpha_ff, gain_ff;
   logic [25:0] base_ff, clamp_ff;
   logic [24:0] reserve_ff;
   logic [31:0] torque_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
         k2_ff <= '0;
         alpha_ff <= '0;
         base_ff <= 26'd3276800;
         reserve_ff <= '0;
         gain_ff <= '0;
         clamp_ff <= '0;
         torque_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            mpml_pkg::REG_COPPER: k1_ff <= csr_data[20:0];
            mpml_pkg::REG_FRICTION: k2_ff <= csr_data[20:0];
            mpml_pkg::REG_STATIC: alpha_ff <= csr_data[22:0];
            mpml_pkg::REG_BASE: base_ff <= csr_data[25:0];
            mpml_pkg::REG_RESERVE: reserve_ff <= csr_data[24:0];
            mpml_pkg::REG_GAIN: gain_ff <= csr_data[22:0];
            mpml_pkg::REG_CLAMP: clamp_ff <= csr_data[25:0];
            mpml_pkg::REG_TORQUE: torque_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // Valid bits of the front stages.
   logic [11:1] v_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[10:1], accept};
      end
   end

   // Stage 1: captured request.
   logic [M-1:0][15:0] cmd1_ff;
   logic [M-1:0][26:0] spd1_ff;
   logic [24:0] energy1_ff;

   always_ff @(posedge clock) begin
      cmd1_ff <= {req_command_d, req_command_c, req_command_b, req_command_a};
      spd1_ff <= {req_speed_d, req_speed_c, req_speed_b, req_speed_a};
      energy1_ff <= req_buffer_energy;
   end

   // Stage 2: magnitudes.
   logic [M-1:0][16:0] cmag2_ff, cmag2_in;
   logic [M-1:0] neg2_ff, neg2_in;
   logic [M-1:0][26:0] w2_ff, w2_in;
   logic dneg2_ff, dneg2_in;
   logic [24:0] dmag2_ff, dmag2_in;
   logic [25:0] diff;

   always_comb begin
      for (int i = 0; i < M; i++) begin
         neg2_in[i] = cmd1_ff[i][15];
         cmag2_in[i] = cmd1_ff[i][15] ? 17'(17'h10000 - {1'b0, cmd1_ff[i]}) : {1'b0, cmd1_ff[i]};
         w2_in[i] = spd1_ff[i][26] ? 27'(28'h8000000 - {1'b0, spd1_ff[i]}) : spd1_ff[i];
      end
      diff = {1'b0, energy1_ff} - {1'b0, reserve_ff};
      dneg2_in = diff[25];
      dmag2_in = diff[25] ? 25'(-diff) : diff[24:0];
   end

   always_ff @(posedge clock) begin
      cmag2_ff <= cmag2_in;
      neg2_ff <= neg2_in;
      w2_ff <= w2_in;
      dneg2_ff <= dneg2_in;
      dmag2_ff <= dmag2_in;
   end

   // Stage 3: torques and buffer product.
   logic [M-1:0][30:0] t3_ff, t3_in;
   logic [M-1:0][16:0] cmag3_ff;
   logic [M-1:0] neg3_ff;
   logic [M-1:0][26:0] w3_ff;
   logic dneg3_ff;
   logic [47:0] bprod3_ff;
   logic [48:0] tprod [M];

   always_comb begin
      for (int i = 0; i < M; i++) begin
         tprod[i] = 49'(cmag2_ff[i]) * 49'(torque_ff);
         t3_in[i] = tprod[i][46:16];
      end
   end

   always_ff @(posedge clock) begin
      t3_ff <= t3_in;
      cmag3_ff <= cmag2_ff;
      neg3_ff <= neg2_ff;
      w3_ff <= w2_ff;
      dneg3_ff <= dneg2_ff;
      bprod3_ff <= 48'(dmag2_ff) * 48'(gain_ff);
   end

   // Stage 4: per-motor products and clamped buffer power.
   logic [M-1:0][41:0] wt4_ff, wt4_in;
   logic [M-1:0][45:0] tt4_ff, tt4_in;
   logic [M-1:0][37:0] ww4_ff, ww4_in;
   logic [M-1:0][16:0] cmag4_ff;
   logic [M-1:0] neg4_ff;
   logic dneg4_ff;
   logic [25:0] bpm4_ff, bpm4_in;
   logic [57:0] wtp [M];
   logic [61:0] ttp [M];
   logic [53:0] wwp [M];
   logic [31:0] bsh;

   always_comb begin
      for (int i = 0; i < M; i++) begin
         wtp[i] = 58'(w3_ff[i]) * 58'(t3_ff[i]);
         ttp[i] = 62'(t3_ff[i]) * 62'(t3_ff[i]);
         wwp[i] = 54'(w3_ff[i]) * 54'(w3_ff[i]);
         wt4_in[i] = wtp[i][57:F];
         tt4_in[i] = ttp[i][61:F];
         ww4_in[i] = wwp[i][53:F];
      end
      bsh = bprod3_ff[47:F];
      bpm4_in = (bsh > {6'b0, clamp_ff}) ? clamp_ff : bsh[25:0];
   end

   always_ff @(posedge clock) begin
      wt4_ff <= wt4_in;
      tt4_ff <= tt4_in;
      ww4_ff <= ww4_in;
      cmag4_ff <= cmag3_ff;
      neg4_ff <= neg3_ff;
      dneg4_ff <= dneg3_ff;
      bpm4_ff <= bpm4_in;
   end

   // Stage 5: sums and budget.
   logic [43:0] b5_ff, b5_in;
   logic [47:0] tsq5_ff, tsq5_in;
   logic [39:0] wsq5_ff, wsq5_in;
   logic [26:0] lim5_ff, lim5_in;
   logic [M-1:0][16:0] cmag5_ff;
   logic [M-1:0] neg5_ff;
   logic [27:0] total;

   always_comb begin
      b5_in = '0;
      tsq5_in = '0;
      wsq5_in = '0;
      for (int i = 0; i < M; i++) begin
         b5_in = b5_in + 44'(wt4_ff[i]);
         tsq5_in = tsq5_in + 48'(tt4_ff[i]);
         wsq5_in = wsq5_in + 40'(ww4_ff[i]);
      end
      total = dneg4_ff ? 28'(base_ff) - 28'(bpm4_ff) : 28'(base_ff) + 28'(bpm4_ff);
      lim5_in = total[27] ? 27'(-total) : total[26:0];
   end

   always_ff @(posedge clock) begin
      b5_ff <= b5_in;
      tsq5_ff <= tsq5_in;
      wsq5_ff <= wsq5_in;
      lim5_ff <= lim5_in;
      cmag5_ff <= cmag4_ff;
      neg5_ff <= neg4_ff;
   end

   // Stage 6: copper and friction partial products.
   logic [44:0] alo6_ff, ahi6_ff, klo6_ff;
   logic [36:0] khi6_ff;
   logic [43:0] b6_ff;
   logic [26:0] lim6_ff;
   logic [M-1:0][16:0] cmag6_ff;
   logic [M-1:0] neg6_ff;

   always_ff @(posedge clock) begin
      alo6_ff <= 45'(k1_ff) * 45'(tsq5_ff[23:0]);
      ahi6_ff <= 45'(k1_ff) * 45'(tsq5_ff[47:24]);
      klo6_ff <= 45'(k2_ff) * 45'(wsq5_ff[23:0]);
      khi6_ff <= 37'(k2_ff) * 37'(wsq5_ff[39:24]);
      b6_ff <= b5_ff;
      lim6_ff <= lim5_ff;
      cmag6_ff <= cmag5_ff;
      neg6_ff <= neg5_ff;
   end

   // Stage 7: copper and friction terms.
   logic [52:0] a7_ff;
   logic [44:0] kw7_ff;
   logic [43:0] b7_ff;
   logic [26:0] lim7_ff;
   logic [M-1:0][16:0] cmag7_ff;
   logic [M-1:0] neg7_ff;
   logic [68:0] afull;
   logic [60:0] kfull;

   always_comb begin
      afull = 69'(alo6_ff) + {ahi6_ff, 24'b0};
      kfull = 61'(klo6_ff) + {khi6_ff, 24'b0};
   end

   always_ff @(posedge clock) begin
      a7_ff <= afull[68:F];
      kw7_ff <= kfull[60:F];
      b7_ff <= b6_ff;
      lim7_ff <= lim6_ff;
      cmag7_ff <= cmag6_ff;
      neg7_ff <= neg6_ff;
   end

   // Stage 8: fixed losses and speed-torque sum.
   logic [45:0] fx8_ff;
   logic [53:0] ab8_ff;
   logic [52:0] a8_ff;
   logic [43:0] b8_ff;
   logic [26:0] lim8_ff;
   logic [M-1:0][16:0] cmag8_ff;
   logic [M-1:0] neg8_ff;

   always_ff @(posedge clock) begin
      fx8_ff <= 46'(kw7_ff) + {21'b0, alpha_ff, 2'b00};
      ab8_ff <= 54'(a7_ff) + 54'(b7_ff);
      a8_ff <= a7_ff;
      b8_ff <= b7_ff;
      lim8_ff <= lim7_ff;
      cmag8_ff <= cmag7_ff;
      neg8_ff <= neg7_ff;
   end

   // Stage 9: total power and headroom.
   logic [54:0] p9_ff;
   logic fxge9_ff;
   logic [26:0] cc9_ff;
   logic [52:0] a9_ff;
   logic [43:0] b9_ff;
   logic [26:0] lim9_ff;
   logic [M-1:0][16:0] cmag9_ff;
   logic [M-1:0] neg9_ff;

   always_ff @(posedge clock) begin
      p9_ff <= 55'(ab8_ff) + 55'(fx8_ff);
      fxge9_ff <= fx8_ff >= 46'(lim8_ff);
      cc9_ff <= lim8_ff - fx8_ff[26:0];
      a9_ff <= a8_ff;
      b9_ff <= b8_ff;
      lim9_ff <= lim8_ff;
      cmag9_ff <= cmag8_ff;
      neg9_ff <= neg8_ff;
   end

   // Stage 10: case selection and radicand partial products.
   mpml_pkg::side_type side10_ff, side10_in;
   logic [63:0] bll10_ff;
   logic [43:0] blh10_ff;
   logic [23:0] bhh10_ff;
   logic [60:0] alc10_ff;
   logic [49:0] ahc10_ff;
   logic [43:0] b10_ff;
   logic [26:0] cc10_ff;
   logic [28:0] cc4;

   always_comb begin
      side10_in.cmag = cmag9_ff;
      side10_in.neg = neg9_ff;
      side10_in.power = p9_ff;
      if (p9_ff <= 55'(lim9_ff)) begin
         side10_in.mode = mpml_pkg::MODE_ONE;
      end else if (fxge9_ff) begin
         side10_in.mode = mpml_pkg::MODE_ZERO;
      end else begin
         side10_in.mode = mpml_pkg::MODE_SOLVE;
      end
      cc4 = {cc9_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      side10_ff <= side10_in;
      bll10_ff <= 64'(b9_ff[31:0]) * 64'(b9_ff[31:0]);
      blh10_ff <= 44'(b9_ff[31:0]) * 44'(b9_ff[43:32]);
      bhh10_ff <= 24'(b9_ff[43:32]) * 24'(b9_ff[43:32]);
      alc10_ff <= 61'(a9_ff[31:0]) * 61'(cc4);
      ahc10_ff <= 50'(a9_ff[52:32]) * 50'(cc4);
      b10_ff <= b9_ff;
      cc10_ff <= cc9_ff;
   end

   // Stage 11: partial sums.
   mpml_pkg::side_type side11_ff;
   logic [87:0] bsq11_ff;
   logic [81:0] ac11_ff;
   logic [43:0] b11_ff;
   logic [26:0] cc11_ff;

   always_ff @(posedge clock) begin
      side11_ff <= side10_ff;
      bsq11_ff <= 88'(bll10_ff) + {11'b0, blh10_ff, 33'b0} + {bhh10_ff, 64'b0};
      ac11_ff <= 82'(alc10_ff) + {ahc10_ff, 32'b0};
      b11_ff <= b10_ff;
      cc11_ff <= cc10_ff;
   end

   // Stage 12 and the square root stages.
   mpml_pkg::sq_type sq_ff [NS+1];
   mpml_pkg::sq_type sq_in [NS+1];
   logic [NS:0] sv_ff;

   always_comb begin
      sq_in[0].side = side11_ff;
      sq_in[0].b = b11_ff;
      sq_in[0].cc = cc11_ff;
      sq_in[0].rad = 90'(bsq11_ff) + 90'(ac11_ff);
      sq_in[0].rem = '0;
      sq_in[0].root = '0;
   end

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      logic [47:0] rem_sh, trial;
      logic take;

      always_comb begin
         rem_sh = {sq_ff[j].rem[45:0], sq_ff[j].rad[89:88]};
         trial = {1'b0, sq_ff[j].root, 2'b01};
         take = rem_sh >= trial;
         sq_in[j+1] = sq_ff[j];
         sq_in[j+1].rad = {sq_ff[j].rad[87:0], 2'b00};
         sq_in[j+1].rem = take ? rem_sh - trial : rem_sh;
         sq_in[j+1].root = {sq_ff[j].root[43:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else begin
         sv_ff <= {sv_ff[NS-1:0], v_ff[11]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= NS; j++) begin
         sq_ff[j] <= sq_in[j];
      end
   end

   // Denominator stage and the divide stages.
   mpml_pkg::div_type dv_ff [ND+1];
   mpml_pkg::div_type dv_in [ND+1];
   logic [ND:0] dvv_ff;
   logic [45:0] den;
   logic [27:0] num;

   always_comb begin
      den = 46'(sq_ff[NS].b) + 46'(sq_ff[NS].root);
      num = {sq_ff[NS].cc, 1'b0};
      dv_in[0].side = sq_ff[NS].side;
      dv_in[0].den = den;
      dv_in[0].rem = 47'(num);
      dv_in[0].quo = '0;
      if (sq_ff[NS].side.mode == mpml_pkg::MODE_SOLVE) begin
         if (den == '0) begin
            dv_in[0].side.mode = mpml_pkg::MODE_ZERO;
         end else if (46'(num) >= den) begin
            dv_in[0].side.mode = mpml_pkg::MODE_ONE;
         end
      end
   end

   for (genvar j = 0; j < ND; j++) begin : g_div
      logic [46:0] rem_sh;
      logic take;

      always_comb begin
         rem_sh = {dv_ff[j].rem[45:0], 1'b0};
         take = rem_sh >= 47'(dv_ff[j].den);
         dv_in[j+1] = dv_ff[j];
         dv_in[j+1].rem = take ? rem_sh - 47'(dv_ff[j].den) : rem_sh;
         dv_in[j+1].quo = {dv_ff[j].quo[14:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvv_ff <= '0;
      end else begin
         dvv_ff <= {dvv_ff[ND-1:0], sv_ff[NS]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= ND; j++) begin
         dv_ff[j] <= dv_in[j];
      end
   end

   // Scale stage.
   logic [16:0] k_in, k_ff;
   logic [M-1:0][33:0] prod_ff;
   logic [M-1:0] negs_ff;
   logic [54:0] pows_ff;
   logic vs_ff;

   always_comb begin
      case (dv_ff[ND].side.mode)
         mpml_pkg::MODE_ONE: k_in = mpml_pkg::SCALE_ONE;
         mpml_pkg::MODE_SOLVE: k_in = {1'b0, dv_ff[ND].quo};
         default: k_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      for (int i = 0; i < M; i++) begin
         prod_ff[i] <= 34'(dv_ff[ND].side.cmag[i]) * 34'(k_in);
      end
      negs_ff <= dv_ff[ND].side.neg;
      pows_ff <= dv_ff[ND].side.power;
   end

   // Output stage.
   logic [M-1:0][15:0] scaled_ff, scaled_in;
   logic [16:0] scale_ff;
   logic [31:0] power_ff;
   logic vo_ff;
   logic [15:0] q;

   always_comb begin
      for (int i = 0; i < M; i++) begin
         q = prod_ff[i][31:16];
         scaled_in[i] = negs_ff[i] ? 16'(-q) : q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vs_ff <= dvv_ff[ND];
         vo_ff <= vs_ff;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      scale_ff <= k_ff;
      power_ff <= (pows_ff[54:32] != '0) ? 32'hFFFF_FFFF : pows_ff[31:0];
   end

   assign rsp_valid = vo_ff;
   assign rsp_scaled_a = scaled_ff[0];
   assign rsp_scaled_b = scaled_ff[1];
   assign rsp_scaled_c = scaled_ff[2];
   assign rsp_scaled_d = scaled_ff[3];
   assign rsp_scale_factor = scale_ff;
   assign rsp_predicted_power = power_ff;

endmodule

`default_nettype wire

[sv/mpml_checker.sv]
// Port-level checks for the four-motor power limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mpml_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic signed [15:0] req_command_a,
   input wire logic               rsp_valid,
   input wire logic signed [15:0] rsp_scaled_a,
   input wire logic [16:0]        rsp_scale_factor
);

   localparam int LAT = mpml_pkg::LATENCY;

   // Every request transfer yields exactly one response a fixed time later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, LAT))
      else $error("response strobe does not match request transfer");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scale_factor <= mpml_pkg::SCALE_ONE)
      else $error("scale above one");

   a_unity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scale_factor == mpml_pkg::SCALE_ONE)
         |-> rsp_scaled_a == $past(req_command_a, LAT))
      else $error("unity scale changed the command");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scale_factor == '0) |-> rsp_scaled_a == '0)
      else $error("zero scale left a command");

endmodule

bind motor_power_model_limiter_unit mpml_checker u_mpml_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_command_a(req_command_a),
   .rsp_valid(rsp_valid),
   .rsp_scaled_a(rsp_scaled_a),
   .rsp_scale_factor(rsp_scale_factor)
);

`default_nettype wire
